// ----- hw/rtl/lslf_pkg.sv -----
// shared constants, widths and status codes for the least squares line fit
package lslf_pkg;

   // point capacity and derived widths
   localparam int MAX_POINTS = 64;
   localparam int CW         = $clog2(MAX_POINTS + 1);   // point count
   localparam int AW         = $clog2(MAX_POINTS);       // point store address
   localparam int CW_IN      = 16;                       // coordinate width
   localparam int SXW        = CW_IN + CW;               // sum_x, sum_y
   localparam int SXXW       = 2 * CW_IN + CW;           // sum_xx, sum_xy

   // shared multiplier operand and product widths
   localparam int MAW = SXXW + 1;
   localparam int MBW = SXW + 1;
   localparam int PW  = MAW + MBW;

   // solve terms, divider numerator and results
   localparam int TW      = PW + 1;             // det, slope and intercept numerators
   localparam int FRAC    = 16;                 // fraction bits of slope and intercept
   localparam int NW      = TW + FRAC;          // divider numerator magnitude
   localparam int OW      = 48;                 // result field width
   localparam int SLO     = 23;                 // low slice of slope for the residual
   localparam int EW      = 64;                 // residual error width
   localparam int EHW     = 20;                 // half of the squared error operand
   localparam int ACCW    = 4 * EHW + 1;        // squared error sum incl. saturation bit
   localparam int RES_LSB = 32;                 // residual = sum >> 32

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_SINGULAR = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

endpackage

// ----- hw/rtl/lslf_ram.sv -----
// generic single write port ram with registered read
module lslf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

// ----- hw/rtl/lslf_mul.sv -----
// shared signed multiplier with registered product
module lslf_mul
   import lslf_pkg::*;
(
   input  logic                 clock,
   input  logic signed [MAW-1:0] op_a,
   input  logic signed [MBW-1:0] op_b,
   output logic signed [PW-1:0]  prod
);

   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] prod_in;

   // product of the selected operands
   assign prod_in = PW'(op_a) * PW'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- hw/rtl/lslf_div.sv -----
// restoring divider, one quotient bit per cycle, saturated 48-bit signed quotient
module lslf_div
   import lslf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [TW-1:0] num,
   input  logic [TW-2:0]        den,
   output logic                 done,
   output logic signed [OW-1:0] quot
);

   localparam int NCW = $clog2(NW);

   logic           run_ff, run_in;
   logic           fin_ff, fin_in;
   logic [NCW-1:0] cnt_ff, cnt_in;
   logic           neg_ff, neg_in;
   logic [NW-1:0]  mag_ff, mag_in;
   logic [TW-2:0]  rem_ff, rem_in;
   logic [NW-1:0]  q_ff, q_in;
   logic [TW-2:0]  den_ff, den_in;

   logic [TW-1:0]  abs_num;
   logic [TW-1:0]  r2;
   logic [TW-1:0]  diff;
   logic           ge;
   logic           q_hi_pos;
   logic           q_over_neg;
   logic [OW-1:0]  q_neg;

   // one shift and subtract step
   always_comb begin
      abs_num = num[TW-1] ? TW'(-num) : TW'(num);
      r2      = {rem_ff, mag_ff[NW-1]};
      diff    = r2 - {1'b0, den_ff};
      ge      = (r2 >= {1'b0, den_ff});

      run_in = run_ff;
      fin_in = 1'b0;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      mag_in = mag_ff;
      rem_in = rem_ff;
      q_in   = q_ff;
      den_in = den_ff;

      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         neg_in = num[TW-1];
         mag_in = {abs_num, {FRAC{1'b0}}};
         rem_in = '0;
         q_in   = '0;
         den_in = den;
      end else if (run_ff) begin
         mag_in = {mag_ff[NW-2:0], 1'b0};
         rem_in = ge ? diff[TW-2:0] : r2[TW-2:0];
         q_in   = {q_ff[NW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == NCW'(NW - 1)) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         fin_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         fin_ff <= fin_in;
      end
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   // sign and saturation of the finished quotient
   always_comb begin
      q_hi_pos   = |q_ff[NW-1:OW-1];
      q_over_neg = (|q_ff[NW-1:OW]) || (q_ff[OW-1] && (|q_ff[OW-2:0]));
      q_neg      = (~q_ff[OW-1:0]) + 1'b1;
      if (neg_ff) begin
         quot = q_over_neg ? $signed({1'b1, {(OW-1){1'b0}}}) : $signed(q_neg);
      end else begin
         quot = q_hi_pos ? $signed({1'b0, {(OW-1){1'b1}}}) : $signed(q_ff[OW-1:0]);
      end
   end

   assign done = fin_ff;

endmodule

// ----- hw/rtl/least_squares_line_fit.sv -----
// least squares line fit: top level with sequencer, sums and point store
//
// Points arrive on the req_ channel and are taken only while the sequencer is
// idle: the word is stored and added to the sums, and x*x and x*y pass through
// the single shared multiplier before the next point is taken. The word with
// last_point set starts the fit, during which the block takes no input: det
// and the two numerators are formed on the shared multiplier, then come two
// 81-step restoring divisions (slope, then intercept), then a walk over the
// stored points for the residual, skipping the squaring of a point whose
// error alone saturates the sum, and last the result is loaded. The result
// waits in an output register, so points of the next run are taken while it
// is still not collected. det <= 0 returns zero fields with status singular
// (overflow if points were dropped); points beyond the 64 slot store are
// dropped and the result reports status overflow.
module least_squares_line_fit
   import lslf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [15:0]   req_x_coord,
   input  logic signed [15:0]   req_y_coord,
   input  logic                 req_last_point,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [OW-1:0] rsp_slope,
   output logic signed [OW-1:0] rsp_intercept,
   output logic [OW-1:0]        rsp_residual,
   output logic [1:0]           rsp_status
);

   // sequencer states
   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_PXX  = 5'd1;
   localparam logic [4:0] S_PXY  = 5'd2;
   localparam logic [4:0] S_PEND = 5'd3;
   localparam logic [4:0] S_F0   = 5'd4;
   localparam logic [4:0] S_F1   = 5'd5;
   localparam logic [4:0] S_F2   = 5'd6;
   localparam logic [4:0] S_F3   = 5'd7;
   localparam logic [4:0] S_F4   = 5'd8;
   localparam logic [4:0] S_F5   = 5'd9;
   localparam logic [4:0] S_F6   = 5'd10;
   localparam logic [4:0] S_DVS  = 5'd11;
   localparam logic [4:0] S_DVI  = 5'd12;
   localparam logic [4:0] S_RD   = 5'd13;
   localparam logic [4:0] S_E0   = 5'd14;
   localparam logic [4:0] S_E1   = 5'd15;
   localparam logic [4:0] S_E2   = 5'd16;
   localparam logic [4:0] S_E3   = 5'd17;
   localparam logic [4:0] S_E4   = 5'd18;
   localparam logic [4:0] S_E5   = 5'd19;
   localparam logic [4:0] S_E6   = 5'd20;
   localparam logic [4:0] S_E7   = 5'd21;
   localparam logic [4:0] S_E8   = 5'd22;
   localparam logic [4:0] S_E9   = 5'd23;
   localparam logic [4:0] S_NX   = 5'd24;
   localparam logic [4:0] S_FIN  = 5'd25;

   localparam logic [ACCW-1:0] ACC_SAT = {1'b1, {(ACCW-1){1'b0}}};

   function automatic logic [ACCW-1:0] sat_add(input logic [ACCW-1:0] a,
                                                input logic [ACCW-1:0] t);
      logic [ACCW-1:0] s;
      begin
         s = a + t;
         if (a[ACCW-1] || s[ACCW-1]) begin
            sat_add = ACC_SAT;
         end else begin
            sat_add = s;
         end
      end
   endfunction

   logic [4:0]             state_ff, state_in;
   logic signed [15:0]     x_ff, x_in;
   logic signed [15:0]     y_ff, y_in;
   logic                   last_ff, last_in;
   logic                   take_ff, take_in;
   logic [CW-1:0]          count_ff, count_in;
   logic signed [SXW-1:0]  sx_ff, sx_in;
   logic signed [SXW-1:0]  sy_ff, sy_in;
   logic signed [SXXW-1:0] sxx_ff, sxx_in;
   logic signed [SXXW-1:0] sxy_ff, sxy_in;
   logic                   ovf_ff, ovf_in;
   logic signed [TW-1:0]   t_ff, t_in;
   logic signed [TW-1:0]   det_ff, det_in;
   logic signed [TW-1:0]   ns_ff, ns_in;
   logic signed [TW-1:0]   ni_ff, ni_in;
   logic signed [OW-1:0]   slope_ff, slope_in;
   logic signed [OW-1:0]   icpt_ff, icpt_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic signed [EW-1:0]   e_ff, e_in;
   logic [2*EHW-1:0]       me_ff, me_in;
   logic [ACCW-1:0]        acc_ff, acc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [OW-1:0]   rsp_slope_ff, rsp_slope_in;
   logic signed [OW-1:0]   rsp_icpt_ff, rsp_icpt_in;
   logic [OW-1:0]          rsp_res_ff, rsp_res_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;

   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   logic [31:0]            ram_wdata;
   logic [31:0]            ram_rdata;
   logic signed [MAW-1:0]  mul_a;
   logic signed [MBW-1:0]  mul_b;
   logic signed [PW-1:0]   mul_prod;
   logic                   div_start;
   logic signed [TW-1:0]   div_num;
   logic                   div_done;
   logic signed [OW-1:0]   div_quot;

   logic                   det_pos;
   logic signed [15:0]     rd_x;
   logic signed [15:0]     rd_y;
   logic [EW-1:0]          e_abs;
   logic [CW-1:0]          idx_next;
   logic signed [MBW-1:0]  n_b;

   lslf_ram #(
      .WIDTH (32),
      .DEPTH (MAX_POINTS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (idx_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   lslf_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   lslf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (det_ff[TW-2:0]),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign det_pos   = !det_ff[TW-1] && (det_ff != '0);
   assign rd_x      = $signed(ram_rdata[31:16]);
   assign rd_y      = $signed(ram_rdata[15:0]);
   assign e_abs     = e_ff[EW-1] ? EW'(-e_ff) : EW'(e_ff);
   assign idx_next  = idx_ff + 1'b1;
   assign n_b       = MBW'($signed({1'b0, count_ff}));
   assign ram_waddr = count_ff[AW-1:0];
   assign ram_wdata = {req_x_coord, req_y_coord};

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_PXX: begin
            mul_a = MAW'(x_ff);
            mul_b = MBW'(x_ff);
         end
         S_PXY: begin
            mul_a = MAW'(x_ff);
            mul_b = MBW'(y_ff);
         end
         S_F0: begin
            mul_a = MAW'(sxx_ff);
            mul_b = n_b;
         end
         S_F1: begin
            mul_a = MAW'(sx_ff);
            mul_b = MBW'(sx_ff);
         end
         S_F2: begin
            mul_a = MAW'(sxy_ff);
            mul_b = n_b;
         end
         S_F3: begin
            mul_a = MAW'(sy_ff);
            mul_b = MBW'(sx_ff);
         end
         S_F4: begin
            mul_a = MAW'(sxx_ff);
            mul_b = MBW'(sy_ff);
         end
         S_F5: begin
            mul_a = MAW'(sxy_ff);
            mul_b = MBW'(sx_ff);
         end
         S_E1: begin
            mul_a = MAW'($signed(slope_ff[OW-1:SLO]));
            mul_b = MBW'(rd_x);
         end
         S_E2: begin
            mul_a = MAW'($signed({1'b0, slope_ff[SLO-1:0]}));
            mul_b = MBW'(rd_x);
         end
         S_E6: begin
            mul_a = MAW'($signed({1'b0, me_ff[EHW-1:0]}));
            mul_b = MBW'($signed({1'b0, me_ff[EHW-1:0]}));
         end
         S_E7: begin
            mul_a = MAW'($signed({1'b0, me_ff[EHW-1:0]}));
            mul_b = MBW'($signed({1'b0, me_ff[2*EHW-1:EHW]}));
         end
         S_E8: begin
            mul_a = MAW'($signed({1'b0, me_ff[2*EHW-1:EHW]}));
            mul_b = MBW'($signed({1'b0, me_ff[2*EHW-1:EHW]}));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer and datapath next state
   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      last_in       = last_ff;
      take_in       = take_ff;
      count_in      = count_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      sxx_in        = sxx_ff;
      sxy_in        = sxy_ff;
      ovf_in        = ovf_ff;
      t_in          = t_ff;
      det_in        = det_ff;
      ns_in         = ns_ff;
      ni_in         = ni_ff;
      slope_in      = slope_ff;
      icpt_in       = icpt_ff;
      idx_in        = idx_ff;
      e_in          = e_ff;
      me_in         = me_ff;
      acc_in        = acc_ff;
      rsp_slope_in  = rsp_slope_ff;
      rsp_icpt_in   = rsp_icpt_ff;
      rsp_res_in    = rsp_res_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      ram_we        = 1'b0;
      div_start     = 1'b0;
      div_num       = ns_ff;

      unique case (state_ff)
         // take a point, store it and add it to the linear sums, or flag overflow when the store is full
         S_IDLE: begin
            if (req_valid) begin
               x_in    = req_x_coord;
               y_in    = req_y_coord;
               last_in = req_last_point;
               take_in = (count_ff < CW'(MAX_POINTS));
               if (count_ff < CW'(MAX_POINTS)) begin
                  ram_we   = 1'b1;
                  count_in = count_ff + 1'b1;
                  sx_in    = sx_ff + SXW'(req_x_coord);
                  sy_in    = sy_ff + SXW'(req_y_coord);
               end else begin
                  ovf_in = 1'b1;
               end
               state_in = S_PXX;
            end
         end
         S_PXX: begin
            state_in = S_PXY;
         end
         S_PXY: begin
            if (take_ff) begin
               sxx_in = sxx_ff + $signed(mul_prod[SXXW-1:0]);
            end
            state_in = S_PEND;
         end
         S_PEND: begin
            if (take_ff) begin
               sxy_in = sxy_ff + $signed(mul_prod[SXXW-1:0]);
            end
            state_in = last_ff ? S_F0 : S_IDLE;
         end
         // det and numerators on the shared multiplier
         S_F0: begin
            state_in = S_F1;
         end
         S_F1: begin
            t_in     = TW'(mul_prod);
            state_in = S_F2;
         end
         S_F2: begin
            det_in   = t_ff - TW'(mul_prod);
            state_in = S_F3;
         end
         S_F3: begin
            t_in     = TW'(mul_prod);
            state_in = S_F4;
         end
         S_F4: begin
            ns_in    = t_ff - TW'(mul_prod);
            state_in = S_F5;
         end
         S_F5: begin
            t_in     = TW'(mul_prod);
            state_in = S_F6;
         end
         S_F6: begin
            ni_in = t_ff - TW'(mul_prod);
            if (det_pos) begin
               div_start = 1'b1;
               div_num   = ns_ff;
               state_in  = S_DVS;
            end else begin
               slope_in = '0;
               icpt_in  = '0;
               acc_in   = '0;
               state_in = S_FIN;
            end
         end
         // slope then intercept through the divider
         S_DVS: begin
            if (div_done) begin
               slope_in  = div_quot;
               div_start = 1'b1;
               div_num   = ni_ff;
               state_in  = S_DVI;
            end
         end
         S_DVI: begin
            if (div_done) begin
               icpt_in  = div_quot;
               idx_in   = '0;
               acc_in   = '0;
               state_in = S_RD;
            end
         end
         // residual walk over the stored points
         S_RD: begin
            state_in = S_E0;
         end
         S_E0: begin
            e_in     = $signed(EW'($signed({rd_y, {FRAC{1'b0}}}))) - EW'(icpt_ff);
            state_in = S_E1;
         end
         S_E1: begin
            state_in = S_E2;
         end
         S_E2: begin
            e_in     = e_ff - (EW'(mul_prod) <<< SLO);
            state_in = S_E3;
         end
         S_E3: begin
            e_in     = e_ff - EW'(mul_prod);
            state_in = S_E4;
         end
         S_E4: begin
            me_in = e_abs[2*EHW-1:0];
            if (|e_abs[EW-1:2*EHW]) begin
               acc_in   = ACC_SAT;
               state_in = S_NX;
            end else begin
               state_in = S_E5;
            end
         end
         S_E5: begin
            state_in = S_E6;
         end
         S_E6: begin
            state_in = S_E7;
         end
         S_E7: begin
            acc_in   = sat_add(acc_ff, ACCW'(mul_prod));
            state_in = S_E8;
         end
         S_E8: begin
            acc_in   = sat_add(acc_ff, ACCW'(mul_prod) << (EHW + 1));
            state_in = S_E9;
         end
         S_E9: begin
            acc_in   = sat_add(acc_ff, ACCW'(mul_prod) << (2 * EHW));
            state_in = S_NX;
         end
         S_NX: begin
            idx_in   = idx_next;
            state_in = (idx_next == count_ff) ? S_FIN : S_RD;
         end
         // load the result word once the output register is free
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_slope_in = slope_ff;
               rsp_icpt_in  = icpt_ff;
               rsp_res_in   = acc_ff[ACCW-1] ? '1 : acc_ff[RES_LSB+OW-1:RES_LSB];
               if (ovf_ff) begin
                  rsp_status_in = ST_OVERFLOW;
               end else if (det_pos) begin
                  rsp_status_in = ST_OK;
               end else begin
                  rsp_status_in = ST_SINGULAR;
               end
               count_in = '0;
               sx_in    = '0;
               sy_in    = '0;
               sxx_in   = '0;
               sxy_in   = '0;
               ovf_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         sxx_ff       <= '0;
         sxy_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         sxx_ff       <= sxx_in;
         sxy_ff       <= sxy_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff          <= x_in;
      y_ff          <= y_in;
      last_ff       <= last_in;
      take_ff       <= take_in;
      t_ff          <= t_in;
      det_ff        <= det_in;
      ns_ff         <= ns_in;
      ni_ff         <= ni_in;
      slope_ff      <= slope_in;
      icpt_ff       <= icpt_in;
      idx_ff        <= idx_in;
      e_ff          <= e_in;
      me_ff         <= me_in;
      acc_ff        <= acc_in;
      rsp_slope_ff  <= rsp_slope_in;
      rsp_icpt_ff   <= rsp_icpt_in;
      rsp_res_ff    <= rsp_res_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_slope     = rsp_slope_ff;
   assign rsp_intercept = rsp_icpt_ff;
   assign rsp_residual  = rsp_res_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ----- hw/rtl/lslf_check.sv -----
// port level checks for the line fit, bound to the top level
module lslf_check
   import lslf_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic signed [OW-1:0] rsp_slope,
   input logic signed [OW-1:0] rsp_intercept,
   input logic [OW-1:0]        rsp_residual,
   input logic [1:0]           rsp_status
);

   // status is one of the three defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_SINGULAR ||
                     rsp_status == ST_OVERFLOW))
      else $error("undefined status code");

   // a singular fit carries zero fields
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_SINGULAR) |->
         (rsp_slope == '0 && rsp_intercept == '0 && rsp_residual == '0))
      else $error("singular fit with nonzero fields");

   // the block is busy for at least the cycle after it takes a point
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("point taken back to back");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_slope) && $stable(rsp_residual)))
      else $error("result word changed while stalled");

endmodule

bind least_squares_line_fit lslf_check u_lslf_check (.*);

// ----- tb/sv/least_squares_line_fit_checker.sv -----
// checker for the least squares line fit: predicts each fit and compares results
module least_squares_line_fit_checker
   import lslf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic signed [15:0]   req_x_coord,
   input  logic signed [15:0]   req_y_coord,
   input  logic                 req_last_point,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic signed [OW-1:0] rsp_slope,
   input  logic signed [OW-1:0] rsp_intercept,
   input  logic [OW-1:0]        rsp_residual,
   input  logic [1:0]           rsp_status,
   output int                   fail_count,
   output int                   fits_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [OW-1:0] slope;
      logic signed [OW-1:0] intercept;
      logic [OW-1:0]        residual;
      logic [1:0]           status;
   } fit_t;

   fit_t fit_queue[$];

   // running state of the current run
   logic signed [15:0] run_x[MAX_POINTS];
   logic signed [15:0] run_y[MAX_POINTS];
   int                 run_count;
   logic signed [63:0] run_sx, run_sy, run_sxx, run_sxy;
   logic               run_over;

   assign fits_pending = fit_queue.size();

   // signed divide of a wide numerator, truncated toward zero, saturated to 48 bits
   function automatic logic signed [OW-1:0] sat_quotient(logic signed [159:0] num,
                                                        logic signed [159:0] den);
      logic signed [159:0] q;
      q = num / den;
      if (q > 160'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
      if (q < -160'sh8000_0000_0000) return 48'sh8000_0000_0000;
      return q[OW-1:0];
   endfunction

   // solve the run and walk the stored points for the residual
   function automatic fit_t solve_run();
      fit_t                f;
      logic signed [159:0] n, det, slope_w, icpt_w, e;
      logic [159:0]        acc;
      n = run_count;
      f = '0;
      det = n * run_sxx - run_sx * run_sx;
      if (det > 0) begin
         f.slope = sat_quotient((n * run_sxy - run_sx * run_sy) <<< 16, det);
         f.intercept = sat_quotient((run_sxx * run_sy - run_sx * run_sxy) <<< 16, det);
         slope_w = f.slope;
         icpt_w = f.intercept;
         acc = 0;
         for (int i = 0; i < run_count; i++) begin
            e = (160'(run_y[i]) <<< 16) - slope_w * run_x[i] - icpt_w;
            if (e < 0) e = -e;
            acc = acc + e * e;
            if (acc >= (160'd1 << 80)) acc = 160'd1 << 80;
         end
         f.residual = (acc >= (160'd1 << 80)) ? '1 : acc[79:32];
         f.status = ST_OK;
      end else begin
         f.status = ST_SINGULAR;
      end
      if (run_over) f.status = ST_OVERFLOW;
      return f;
   endfunction

   // accept points and compare results
   always @(posedge clock) begin
      fit_t got, want;
      if (reset) begin
         run_sx = 0; run_sy = 0; run_sxx = 0; run_sxy = 0;
         run_over = 0;
         run_count = 0;
         fail_count <= 0;
         fit_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_slope, rsp_intercept, rsp_residual, rsp_status};
            if (fit_queue.size() == 0) begin
               $display("%0t: unexpected word slope %0d intercept %0d residual %0d status %0d",
                        $time, got.slope, got.intercept, got.residual, got.status);
               fail_count <= fail_count + 1;
            end else begin
               want = fit_queue.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected slope %0d intercept %0d residual %0d status %0d",
                           $time, want.slope, want.intercept, want.residual, want.status);
                  $display("%0t:            actual slope %0d intercept %0d residual %0d status %0d",
                           $time, got.slope, got.intercept, got.residual, got.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (run_count < MAX_POINTS) begin
               run_x[run_count] = req_x_coord;
               run_y[run_count] = req_y_coord;
               run_count = run_count + 1;
               run_sx = run_sx + req_x_coord;
               run_sy = run_sy + req_y_coord;
               run_sxx = run_sxx + req_x_coord * req_x_coord;
               run_sxy = run_sxy + req_x_coord * req_y_coord;
            end else begin
               run_over = 1;
            end
            if (req_last_point) begin
               fit_queue.push_back(solve_run());
               run_count = 0;
               run_sx = 0; run_sy = 0; run_sxx = 0; run_sxy = 0;
               run_over = 0;
            end
         end
      end
   end
endmodule

// ----- tb/sv/least_squares_line_fit_tb.sv -----
// testbench top for the least squares line fit: stimulus, clocking and verdict
module least_squares_line_fit_tb;
   import lslf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_valid = 0;
   logic                 req_ready;
   logic signed [15:0]   req_x_coord = 0;
   logic signed [15:0]   req_y_coord = 0;
   logic                 req_last_point = 0;
   logic                 rsp_valid;
   logic                 rsp_ready = 0;
   logic signed [OW-1:0] rsp_slope;
   logic signed [OW-1:0] rsp_intercept;
   logic [OW-1:0]        rsp_residual;
   logic [1:0]           rsp_status;
   int                   fail_count;
   int                   fits_pending;
   int                   send_idle_pct = 0;
   int                   recv_stall_pct = 0;
   longint               cycle_count = 0;
   int                   sent = 0;

   localparam longint CYCLE_LIMIT = 3_000_000;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   least_squares_line_fit dut (.*);

   least_squares_line_fit_checker checker_i (.*);

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // runaway guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("least_squares_line_fit regression: fail");
         $finish;
      end
   end

   // present one word and wait for it to be taken
   task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_x_coord <= x;
      req_y_coord <= y;
      req_last_point <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   function automatic logic signed [15:0] rand_coord(int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(64)) - 32);
         2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         default: return 16'($signed($urandom_range(2000)) - 1000);
      endcase
   endfunction

   // one run of random points, mostly short, now and then 60 to 70 long so that it can overflow the store
   task automatic send_run();
      int n, mode, slope_m, icpt;
      logic signed [15:0] x;
      logic signed [31:0] y;
      n = ($urandom_range(19) == 0) ? $urandom_range(70, 60) : $urandom_range(8, 1);
      mode = $urandom_range(3);
      slope_m = $signed($urandom_range(20)) - 10;
      icpt = $signed($urandom_range(2000)) - 1000;
      for (int i = 0; i < n; i++) begin
         x = rand_coord(mode);
         if ($urandom_range(1)) y = 32'(rand_coord(mode));
         else y = slope_m * x + icpt + $signed($urandom_range(6)) - 3;
         if (y > 32767) y = 32767;
         if (y < -32768) y = -32768;
         if ($urandom_range(9) == 0) x = 0;
         send_point(x, y[15:0], i == n - 1);
      end
   endtask

   initial begin
      int target;
      repeat (3) @(posedge clock);
      reset <= 0;
      // directed: single point, vertical line, extremes, exact lines, overflow
      send_point(16'sh7FFF, 16'sh8000, 1);
      send_point(5, 1, 0); send_point(5, 2, 0); send_point(5, 3, 1);
      send_point(16'sh8000, 16'sh8000, 0); send_point(16'sh7FFF, 16'sh7FFF, 1);
      send_point(16'sh8000, 16'sh7FFF, 0); send_point(16'sh7FFF, 16'sh8000, 1);
      send_point(0, 0, 0); send_point(1, 16'sh7FFF, 0); send_point(-1, 16'sh8000, 1);
      send_point(16'sh8000, 0, 0); send_point(16'sh8000, 1, 0); send_point(16'sh7FFF, 16'sh7FFF, 1);
      for (int i = 0; i < 66; i++) send_point(16'(i * 997), 16'(i * 31 - 500), i == 65);
      target = 1800;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 68; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 68; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         while (sent < 80 + target * (phase + 1) / 4) send_run();
      end
      req_valid <= 0;
      while (fits_pending != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
      if (fail_count == 0) $display("least_squares_line_fit regression: pass");
      else $display("least_squares_line_fit regression: fail");
      $finish;
   end
endmodule

// ----- files.f -----
hw/rtl/lslf_pkg.sv
hw/rtl/lslf_ram.sv
hw/rtl/lslf_mul.sv
hw/rtl/lslf_div.sv
hw/rtl/least_squares_line_fit.sv
hw/rtl/lslf_check.sv
tb/sv/least_squares_line_fit_checker.sv
tb/sv/least_squares_line_fit_tb.sv
